// ===== rtl/ppts_pkg.sv =====
// package for the priority periodic task scheduler
// beat types, table entry layout, controller commands and defaults; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ppts_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int LIMIT_W       = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd10;

    typedef struct packed {
        logic               mode;
        logic [31:0]        now_ms;
        logic [7:0]         task_id;
        logic [31:0]        delay_ms;
        logic signed [15:0] task_priority;
    } item_t;

    typedef struct packed {
        logic       kind;
        logic       status;
        logic [7:0] fired_task;
        logic       is_last;
    } result_t;

    typedef struct packed {
        logic [7:0]         task_id;
        logic [31:0]        last_run;
        logic [31:0]        period;
        logic signed [15:0] rank;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    localparam logic MODE_DECLARE = 1'b0;
    localparam logic MODE_TICK    = 1'b1;

    typedef enum logic [1:0] {
        WR_NEW,
        WR_SHIFT,
        WR_STAMP
    } wr_sel_t;

    typedef enum logic [1:0] {
        OUT_ACCEPT,
        OUT_FULL,
        OUT_FIRED
    } out_sel_t;

    typedef struct packed {
        logic     load_item;
        logic     rd_en;
        logic     wr_en;
        wr_sel_t  wr_sel;
        logic     pend_load;
        logic     out_en;
        out_sel_t out_sel;
        logic     out_last;
    } cmd_t;

    typedef struct packed {
        logic due;
        logic rank_lt;
    } stat_t;

endpackage

`default_nettype wire

// ===== rtl/ppts_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ppts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ppts_dp.sv =====
// datapath: item register, task table ram, due and rank compares, result register
// depends on ppts_pkg and ppts_ram
`timescale 1ns / 1ps
`default_nettype none

module ppts_dp #(
    parameter int MAX_TASKS = ppts_pkg::MAX_TASKS_DEF,
    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ppts_pkg::item_t   item,
    input  wire ppts_pkg::cmd_t    cmd,
    input  wire logic [AW-1:0]     rd_addr,
    input  wire logic [AW-1:0]     wr_addr,
    output ppts_pkg::stat_t        stat,
    output logic                   strobe,
    output ppts_pkg::result_t      result
);

    ppts_pkg::item_t   item_reg;
    ppts_pkg::entry_t  rd_entry;
    ppts_pkg::entry_t  wr_entry;
    logic [ppts_pkg::ENTRY_W-1:0] rd_data;
    logic [7:0]        pend_reg;
    logic              strobe_reg;
    ppts_pkg::result_t result_reg;
    ppts_pkg::result_t result_next;
    logic [31:0]       elapsed;

    ppts_ram #(
        .WIDTH (ppts_pkg::ENTRY_W),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (wr_addr),
        .wdata (wr_entry),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign rd_entry = rd_data;
    assign elapsed  = item_reg.now_ms - rd_entry.last_run;

    assign stat.due     = elapsed > rd_entry.period;
    assign stat.rank_lt = item_reg.task_priority < rd_entry.rank;

    always_comb
    begin
        wr_entry = rd_entry;
        unique case (cmd.wr_sel)
            ppts_pkg::WR_NEW:
            begin
                wr_entry.task_id  = item_reg.task_id;
                wr_entry.last_run = item_reg.now_ms;
                wr_entry.period   = item_reg.delay_ms;
                wr_entry.rank     = item_reg.task_priority;
            end
            ppts_pkg::WR_SHIFT:
            begin
                wr_entry = rd_entry;
            end
            ppts_pkg::WR_STAMP:
            begin
                wr_entry.last_run = item_reg.now_ms;
            end
            default:
            begin
                wr_entry = rd_entry;
            end
        endcase
    end

    always_comb
    begin
        result_next = '0;
        unique case (cmd.out_sel)
            ppts_pkg::OUT_ACCEPT:
            begin
                result_next.is_last = cmd.out_last;
            end
            ppts_pkg::OUT_FULL:
            begin
                result_next.status  = 1'b1;
                result_next.is_last = cmd.out_last;
            end
            ppts_pkg::OUT_FIRED:
            begin
                result_next.kind       = 1'b1;
                result_next.fired_task = pend_reg;
                result_next.is_last    = cmd.out_last;
            end
            default:
            begin
                result_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
        end
        if (cmd.pend_load)
        begin
            pend_reg <= rd_entry.task_id;
        end
        if (cmd.out_en)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= cmd.out_en;
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

// ===== rtl/ppts_ctrl.sv =====
// controller: task count, limit register, declare shift loop and tick walk sequencing
// depends on ppts_pkg
`timescale 1ns / 1ps
`default_nettype none

module ppts_ctrl #(
    parameter int MAX_TASKS = ppts_pkg::MAX_TASKS_DEF,
    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
    localparam int CW = $clog2(MAX_TASKS + 1),
    localparam int LW = (CW > ppts_pkg::LIMIT_W) ? CW : ppts_pkg::LIMIT_W
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          mode,
    input  wire logic                          cfg_we,
    input  wire logic [ppts_pkg::LIMIT_W-1:0]  cfg_data,
    input  wire ppts_pkg::stat_t               stat,
    output logic                               busy,
    output ppts_pkg::cmd_t                     cmd,
    output logic [AW-1:0]                      rd_addr,
    output logic [AW-1:0]                      wr_addr
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_PLACE,
        S_WALK,
        S_FLUSH
    } state_t;

    state_t                         state_reg;
    state_t                         state_next;
    logic [CW-1:0]                  count_reg;
    logic [CW-1:0]                  count_next;
    logic [ppts_pkg::LIMIT_W-1:0]   limit_reg;
    logic [AW-1:0]                  idx_reg;
    logic [AW-1:0]                  idx_next;
    logic                           pend_valid_reg;
    logic                           pend_valid_next;
    logic [LW-1:0]                  eff_limit;
    logic                           full;
    logic                           last_entry;

    assign eff_limit  = (LW'(limit_reg) > LW'(MAX_TASKS)) ? LW'(MAX_TASKS) : LW'(limit_reg);
    assign full       = LW'(count_reg) >= eff_limit;
    assign last_entry = (CW'(idx_reg) + CW'(1)) == count_reg;
    assign busy       = state_reg != S_IDLE;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pend_valid_next = pend_valid_reg;
        cmd             = '0;
        cmd.wr_sel      = ppts_pkg::WR_NEW;
        cmd.out_sel     = ppts_pkg::OUT_ACCEPT;
        rd_addr         = idx_reg;
        wr_addr         = idx_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_item = 1'b1;
                    if (mode == ppts_pkg::MODE_DECLARE)
                    begin
                        if (full)
                        begin
                            cmd.out_en   = 1'b1;
                            cmd.out_sel  = ppts_pkg::OUT_FULL;
                            cmd.out_last = 1'b1;
                        end
                        else if (count_reg == '0)
                        begin
                            idx_next   = '0;
                            state_next = S_PLACE;
                        end
                        else
                        begin
                            cmd.rd_en  = 1'b1;
                            rd_addr    = AW'(count_reg - CW'(1));
                            idx_next   = AW'(count_reg);
                            state_next = S_SHIFT;
                        end
                    end
                    else if (count_reg != '0)
                    begin
                        cmd.rd_en       = 1'b1;
                        rd_addr         = '0;
                        idx_next        = '0;
                        pend_valid_next = 1'b0;
                        state_next      = S_WALK;
                    end
                end
            end
            S_SHIFT:
            begin
                cmd.wr_en = 1'b1;
                if (stat.rank_lt)
                begin
                    cmd.wr_sel   = ppts_pkg::WR_NEW;
                    cmd.out_en   = 1'b1;
                    cmd.out_sel  = ppts_pkg::OUT_ACCEPT;
                    cmd.out_last = 1'b1;
                    count_next   = count_reg + CW'(1);
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.wr_sel = ppts_pkg::WR_SHIFT;
                    idx_next   = idx_reg - AW'(1);
                    if (idx_reg == AW'(1))
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        cmd.rd_en = 1'b1;
                        rd_addr   = idx_reg - AW'(2);
                    end
                end
            end
            S_PLACE:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_sel   = ppts_pkg::WR_NEW;
                cmd.out_en   = 1'b1;
                cmd.out_sel  = ppts_pkg::OUT_ACCEPT;
                cmd.out_last = 1'b1;
                count_next   = count_reg + CW'(1);
                state_next   = S_IDLE;
            end
            S_WALK:
            begin
                if (!last_entry)
                begin
                    cmd.rd_en = 1'b1;
                    rd_addr   = idx_reg + AW'(1);
                end
                if (stat.due)
                begin
                    cmd.wr_en       = 1'b1;
                    cmd.wr_sel      = ppts_pkg::WR_STAMP;
                    cmd.pend_load   = 1'b1;
                    pend_valid_next = 1'b1;
                    if (pend_valid_reg)
                    begin
                        cmd.out_en   = 1'b1;
                        cmd.out_sel  = ppts_pkg::OUT_FIRED;
                        cmd.out_last = 1'b0;
                    end
                end
                if (last_entry)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    idx_next = idx_reg + AW'(1);
                end
            end
            S_FLUSH:
            begin
                if (pend_valid_reg)
                begin
                    cmd.out_en   = 1'b1;
                    cmd.out_sel  = ppts_pkg::OUT_FIRED;
                    cmd.out_last = 1'b1;
                end
                pend_valid_next = 1'b0;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            limit_reg      <= ppts_pkg::LIMIT_RESET;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CW'(MAX_TASKS) >= count_reg)
        else $error("task count beyond table size");

    a_new_entry_acked: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_en && cmd.wr_sel == ppts_pkg::WR_NEW) |-> (cmd.out_en && cmd.out_last))
        else $error("new entry written without declare status");

    a_fired_has_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_en && cmd.out_sel == ppts_pkg::OUT_FIRED) |-> pend_valid_reg)
        else $error("fired beat without pending task");

    a_shift_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (idx_reg != '0 && CW'(idx_reg) == count_reg
            || state_reg == S_SHIFT && idx_reg != '0 && $past(state_reg) == S_SHIFT))
        else $error("shift position out of range");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + CW'(1)))
        else $error("task count moved by other than one");

endmodule

`default_nettype wire

// ===== rtl/priority_periodic_task_scheduler_unit.sv =====
// top level of the priority periodic task scheduler
// depends on ppts_pkg, ppts_ctrl, ppts_dp (and ppts_ram through ppts_dp)
`timescale 1ns / 1ps
`default_nettype none

// An item is taken when start is high and busy is low. A declare that finds the table
// full answers in the next cycle and leaves busy low. Any other declare moves back the
// entries it passes, at most the current task count, before it places the new one; a
// tick walks every entry, but on an empty table it leaves busy low. The task table is a
// ram with one read and one write port, walked one entry per cycle. Results appear as
// single-cycle strobe beats that the receiver must take as they come; a declare gives
// exactly one beat, a tick one beat per task that is due, in table order, with is_last
// on the final one and no beat at all if nothing is due. task_limit may be written only
// while busy is low.
module priority_periodic_task_scheduler_unit #(
    parameter int MAX_TASKS = ppts_pkg::MAX_TASKS_DEF,
    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire ppts_pkg::item_t               item,
    output logic                               strobe,
    output ppts_pkg::result_t                  result,
    input  wire logic                          cfg_we,
    input  wire logic [ppts_pkg::LIMIT_W-1:0]  cfg_data
);

    ppts_pkg::cmd_t  cmd;
    ppts_pkg::stat_t stat;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;

    ppts_ctrl #(
        .MAX_TASKS (MAX_TASKS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .mode     (item.mode),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .stat     (stat),
        .busy     (busy),
        .cmd      (cmd),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr)
    );

    ppts_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .cmd     (cmd),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .stat    (stat),
        .strobe  (strobe),
        .result  (result)
    );

endmodule

`default_nettype wire
